// ===== rtl/bdsf_pkg.sv =====
// ----------------------------------------------------------------------------
// bdsf_pkg
// Shared types and constants of the break-distance segment filter.
// ----------------------------------------------------------------------------
package bdsf_pkg;

    localparam int SEG_DEPTH  = 32;
    localparam int COORD_BITS = 16;

    localparam int IDX_W  = $clog2(SEG_DEPTH);
    localparam int CNT_W  = $clog2(SEG_DEPTH + 1);
    localparam int LEN_W  = 6;
    localparam int CMP_W  = 8;
    localparam int ID_W   = 32;
    localparam int THR_W  = 34;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int SUM_W  = SQ_W + 2;
    localparam int DIST_W = (SUM_W > THR_W) ? SUM_W : THR_W;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    localparam logic [1:0] REG_BREAK_DIST_SQ   = 2'd0;
    localparam logic [1:0] REG_MIN_SEGMENT_LEN = 2'd1;
    localparam logic [1:0] REG_RING_ENABLE     = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic [ID_W-1:0]              point_id;
        logic                         curve_last;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic signed [COORD_BITS-1:0] out_z;
        logic [ID_W-1:0]              out_id;
        logic                         run_last;
        logic                         curve_end;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic [ID_W-1:0]              point_id;
    } t_held_entry;

endpackage

// ===== rtl/bdsf_ram.sv =====
// ----------------------------------------------------------------------------
// bdsf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/break_distance_segment_filter_core.sv =====
// ----------------------------------------------------------------------------
// break_distance_segment_filter_core
// Splits a lidar ring curve into segments at large neighbor gaps, drops short
// segments, except one that ends its curve, and passes the remaining points on in scan order.
// ----------------------------------------------------------------------------
// Flow: a point is taken only in S_IDLE. Its squared gap to the previous point
// is built axis by axis in S_MUL and compared in S_ACC (a point that opens a
// curve skips both); S_DECIDE then passes, holds or flushes it, and a flushed
// segment is read back through S_RD and S_EMIT, one result at a time. The input stalls until the point is finished.
// Reset: synchronous, active low; clears curve state and loads register
// defaults (threshold 0, minimum length 1, ring enabled). No clearing pass.
module break_distance_segment_filter_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  bdsf_pkg::t_in_item                   i_in_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output bdsf_pkg::t_out_item                  o_out_item,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bdsf_pkg::ADDR_W-1:0]          paddr,
    input  logic [bdsf_pkg::DATA_W-1:0]          pwdata,
    output logic [bdsf_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_DECIDE,
        S_RD,
        S_EMIT
    } t_state;

    t_state                          r_state;
    logic [bdsf_pkg::THR_W-1:0]      r_break_dist_sq;
    logic [bdsf_pkg::LEN_W-1:0]      r_min_segment_len;
    logic                            r_ring_enable;

    bdsf_pkg::t_in_item              r_cur;
    bdsf_pkg::t_held_entry           r_prev;
    logic                            r_have_prev;
    logic [bdsf_pkg::CNT_W-1:0]      r_cnt;
    logic                            r_pass;
    logic [1:0]                      r_axis;
    logic [bdsf_pkg::SQ_W-1:0]       r_sq;
    logic [bdsf_pkg::DIST_W-1:0]     r_acc;
    logic [bdsf_pkg::CNT_W-1:0]      r_flush_n;
    logic [bdsf_pkg::CNT_W-1:0]      r_rd_idx;
    logic                            r_out_valid;
    bdsf_pkg::t_out_item             r_out;

    logic                            w_cfg_wr;
    logic                            w_in_xfer;
    logic                            w_out_free;
    logic                            w_out_load;
    logic signed [bdsf_pkg::DIFF_W-1:0]   w_diff;
    logic signed [2*bdsf_pkg::DIFF_W-1:0] w_sq_full;
    logic [bdsf_pkg::DIST_W-1:0]     w_sum;
    logic [bdsf_pkg::DIST_W-1:0]     w_thr;
    logic [bdsf_pkg::CMP_W-1:0]      w_min_eff;
    logic [bdsf_pkg::CNT_W-1:0]      n_cnt;
    logic                            w_flush_now;
    logic                            w_rd_last;
    logic                            w_finish;
    logic                            w_ram_we;
    logic                            w_ram_re;
    bdsf_pkg::t_held_entry           w_wr_entry;
    bdsf_pkg::t_held_entry           w_rd_entry;
    logic signed [bdsf_pkg::COORD_BITS-1:0] w_cur_c;
    logic signed [bdsf_pkg::COORD_BITS-1:0] w_prev_c;

    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        prdata = '0;
        unique case (paddr[4:3])
            bdsf_pkg::REG_BREAK_DIST_SQ:   prdata = bdsf_pkg::DATA_W'(r_break_dist_sq);
            bdsf_pkg::REG_MIN_SEGMENT_LEN: prdata = bdsf_pkg::DATA_W'(r_min_segment_len);
            bdsf_pkg::REG_RING_ENABLE:     prdata = bdsf_pkg::DATA_W'(r_ring_enable);
            default:                       prdata = '0;
        endcase
    end

    // cur/prev coordinate of the axis in work
    always_comb begin
        case (r_axis)
            2'd0: begin
                w_cur_c  = r_cur.pos_x;
                w_prev_c = r_prev.pos_x;
            end
            2'd1: begin
                w_cur_c  = r_cur.pos_y;
                w_prev_c = r_prev.pos_y;
            end
            default: begin
                w_cur_c  = r_cur.pos_z;
                w_prev_c = r_prev.pos_z;
            end
        endcase
    end

    assign w_diff    = $signed({w_cur_c[bdsf_pkg::COORD_BITS-1], w_cur_c})
                     - $signed({w_prev_c[bdsf_pkg::COORD_BITS-1], w_prev_c});
    assign w_sq_full = w_diff * w_diff;
    assign w_sum     = r_acc + {{(bdsf_pkg::DIST_W-bdsf_pkg::SQ_W){1'b0}}, r_sq};
    assign w_thr     = bdsf_pkg::DIST_W'(r_break_dist_sq);

    always_comb begin
        if (r_min_segment_len == '0) begin
            w_min_eff = bdsf_pkg::CMP_W'(1);
        end else if (bdsf_pkg::CMP_W'(r_min_segment_len) > bdsf_pkg::CMP_W'(bdsf_pkg::SEG_DEPTH))
        begin
            w_min_eff = bdsf_pkg::CMP_W'(bdsf_pkg::SEG_DEPTH);
        end else begin
            w_min_eff = bdsf_pkg::CMP_W'(r_min_segment_len);
        end
    end

    assign n_cnt       = r_cnt + bdsf_pkg::CNT_W'(1);
    assign w_flush_now = (bdsf_pkg::CMP_W'(n_cnt) >= w_min_eff) || r_cur.curve_last;
    assign w_rd_last   = (r_rd_idx + bdsf_pkg::CNT_W'(1)) == r_flush_n;

    assign w_ram_we = (r_state == S_DECIDE) && !r_pass;
    assign w_ram_re = (r_state == S_RD);

    assign w_out_load = ((r_state == S_DECIDE) && r_pass && w_out_free)
                     || ((r_state == S_EMIT) && w_out_free);

    always_comb begin
        w_wr_entry.pos_x    = r_cur.pos_x;
        w_wr_entry.pos_y    = r_cur.pos_y;
        w_wr_entry.pos_z    = r_cur.pos_z;
        w_wr_entry.point_id = r_cur.point_id;
    end

    always_comb begin
        w_finish = 1'b0;
        unique case (r_state)
            S_DECIDE: w_finish = r_pass ? w_out_free : !w_flush_now;
            S_EMIT:   w_finish = w_out_free && w_rd_last;
            default:  w_finish = 1'b0;
        endcase
    end

    bdsf_ram #(
        .WIDTH ($bits(bdsf_pkg::t_held_entry)),
        .DEPTH (bdsf_pkg::SEG_DEPTH)
    ) u_held (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_cnt[bdsf_pkg::IDX_W-1:0]),
        .i_wdata (w_wr_entry),
        .i_re    (w_ram_re),
        .i_raddr (r_rd_idx[bdsf_pkg::IDX_W-1:0]),
        .o_rdata (w_rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_break_dist_sq   <= '0;
            r_min_segment_len <= bdsf_pkg::LEN_W'(1);
            r_ring_enable     <= 1'b1;
            r_prev            <= '0;
            r_have_prev       <= 1'b0;
            r_cnt             <= '0;
            r_pass            <= 1'b0;
            r_axis            <= '0;
            r_rd_idx          <= '0;
            r_flush_n         <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                unique case (paddr[4:3])
                    bdsf_pkg::REG_BREAK_DIST_SQ:
                        r_break_dist_sq <= pwdata[bdsf_pkg::THR_W-1:0];
                    bdsf_pkg::REG_MIN_SEGMENT_LEN:
                        r_min_segment_len <= pwdata[bdsf_pkg::LEN_W-1:0];
                    bdsf_pkg::REG_RING_ENABLE:
                        r_ring_enable <= pwdata[0];
                    default: ;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_cur  <= i_in_item;
                        r_axis <= '0;
                        if (!r_ring_enable) begin
                            r_prev      <= '0;
                            r_have_prev <= 1'b0;
                            r_cnt       <= '0;
                            r_pass      <= 1'b0;
                        end else if (r_have_prev) begin
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_DECIDE;
                        end
                    end
                end
                S_MUL: begin
                    r_sq <= w_sq_full[bdsf_pkg::SQ_W-1:0];
                    if (r_axis == 2'd0) begin
                        r_acc <= '0;
                    end else begin
                        r_acc <= w_sum;
                    end
                    if (r_axis == 2'd2) begin
                        r_state <= S_ACC;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                    end
                end
                S_ACC: begin
                    if (w_sum > w_thr) begin
                        r_cnt  <= '0;
                        r_pass <= 1'b0;
                    end
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (r_pass) begin
                        if (w_out_free) begin
                            r_out.out_x     <= r_cur.pos_x;
                            r_out.out_y     <= r_cur.pos_y;
                            r_out.out_z     <= r_cur.pos_z;
                            r_out.out_id    <= r_cur.point_id;
                            r_out.run_last  <= 1'b1;
                            r_out.curve_end <= r_cur.curve_last;
                            r_state         <= S_IDLE;
                        end
                    end else if (w_flush_now) begin
                        r_flush_n <= n_cnt;
                        r_rd_idx  <= '0;
                        r_cnt     <= '0;
                        r_pass    <= 1'b1;
                        r_state   <= S_RD;
                    end else begin
                        r_cnt   <= n_cnt;
                        r_state <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out.out_x     <= w_rd_entry.pos_x;
                        r_out.out_y     <= w_rd_entry.pos_y;
                        r_out.out_z     <= w_rd_entry.pos_z;
                        r_out.out_id    <= w_rd_entry.point_id;
                        r_out.run_last  <= w_rd_last;
                        r_out.curve_end <= w_rd_last && r_cur.curve_last;
                        if (w_rd_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_rd_idx <= r_rd_idx + bdsf_pkg::CNT_W'(1);
                            r_state  <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // retire the item: end of curve clears, else remember the point
            if (w_finish) begin
                if (r_cur.curve_last) begin
                    r_prev      <= '0;
                    r_have_prev <= 1'b0;
                    r_cnt       <= '0;
                    r_pass      <= 1'b0;
                end else begin
                    r_prev.pos_x    <= r_cur.pos_x;
                    r_prev.pos_y    <= r_cur.pos_y;
                    r_prev.pos_z    <= r_cur.pos_z;
                    r_prev.point_id <= r_cur.point_id;
                    r_have_prev     <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== dv/tb_break_distance_segment_filter_core.sv =====
// ----------------------------------------------------------------------------
// tb_break_distance_segment_filter_core
// Self-checking bench for the lidar ring segment filter. A clocked driver
// sends points from a queue and a clocked monitor takes results. Every
// accepted point runs through a behavioral filter that predicts which points
// are kept, in what order, and where run_last and curve_end are set. Each
// result is checked field by field against the oldest prediction. The run
// covers directed corner points, then random curves under several register
// settings and idle patterns. One long output hold-off makes the core hold its
// output and stall its input.
// ----------------------------------------------------------------------------
module tb_break_distance_segment_filter_core;

    localparam int          CLK_PERIOD     = 8;
    localparam int          SETTLE_CYCLES  = 40;
    localparam int          HOLDOFF_CYCLES = 300;
    localparam longint      LIMIT_TIME     = 64'd3200000;
    localparam longint unsigned THR_MAX    = (64'd1 << bdsf_pkg::THR_W) - 1;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    bdsf_pkg::t_in_item            i_in_item;
    logic                          o_out_valid;
    logic                          i_out_stall;
    bdsf_pkg::t_out_item           o_out_item;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [bdsf_pkg::ADDR_W-1:0]   paddr;
    logic [bdsf_pkg::DATA_W-1:0]   pwdata;
    logic [bdsf_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    break_distance_segment_filter_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // register mirror
    logic [bdsf_pkg::THR_W-1:0]    cfg_break_dist_sq;
    logic [bdsf_pkg::LEN_W-1:0]    cfg_min_len;
    logic                          cfg_enable;

    // filter state
    logic signed [bdsf_pkg::COORD_BITS-1:0] last_x, last_y, last_z;
    bit                            have_last;
    int unsigned                   seg_count;
    bit                            passing;
    bdsf_pkg::t_in_item            held_points [bdsf_pkg::SEG_DEPTH];

    bdsf_pkg::t_in_item            point_queue [$];
    bdsf_pkg::t_out_item           kept_points [$];

    int unsigned                   send_idle_pct;
    int unsigned                   recv_idle_pct;
    bit                            holdoff_arm;
    logic                          holdoff_on;
    int unsigned                   err_count;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_TIME);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic longint unsigned sq_gap(logic signed [bdsf_pkg::COORD_BITS-1:0] a,
                                               logic signed [bdsf_pkg::COORD_BITS-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return longint'(d * d);
    endfunction

    function automatic void clear_curve();
        have_last = 1'b0;
        seg_count = 0;
        passing   = 1'b0;
        last_x    = '0;
        last_y    = '0;
        last_z    = '0;
    endfunction

    function automatic bdsf_pkg::t_out_item as_result(bdsf_pkg::t_in_item p);
        bdsf_pkg::t_out_item r;
        r.out_x     = p.pos_x;
        r.out_y     = p.pos_y;
        r.out_z     = p.pos_z;
        r.out_id    = p.point_id;
        r.run_last  = 1'b0;
        r.curve_end = 1'b0;
        return r;
    endfunction

    function automatic void predict_point(bdsf_pkg::t_in_item p);
        int unsigned          min_eff;
        int unsigned          before_cnt;
        int unsigned          slot;
        longint unsigned      dist_sq;
        bdsf_pkg::t_out_item  r;
        if (!cfg_enable) begin
            clear_curve();
            return;
        end
        min_eff = cfg_min_len;
        if (min_eff < 1) min_eff = 1;
        if (min_eff > bdsf_pkg::SEG_DEPTH) min_eff = bdsf_pkg::SEG_DEPTH;
        if (have_last) begin
            dist_sq = sq_gap(p.pos_x, last_x) + sq_gap(p.pos_y, last_y)
                    + sq_gap(p.pos_z, last_z);
            if (dist_sq > longint'(cfg_break_dist_sq)) begin
                seg_count = 0;
                passing   = 1'b0;
            end
        end
        before_cnt = kept_points.size();
        if (passing) begin
            kept_points.insert(kept_points.size(), as_result(p));
        end else begin
            slot = seg_count % bdsf_pkg::SEG_DEPTH;
            held_points[slot] = p;
            seg_count = slot + 1;
            if (seg_count >= min_eff || p.curve_last) begin
                for (int unsigned k = 0; k < seg_count; k++) begin
                    kept_points.insert(kept_points.size(), as_result(held_points[k]));
                end
                seg_count = 0;
                passing   = 1'b1;
            end
        end
        if (kept_points.size() > before_cnt) begin
            r = kept_points.pop_back();
            r.run_last  = 1'b1;
            r.curve_end = p.curve_last;
            kept_points.insert(kept_points.size(), r);
        end
        if (p.curve_last) begin
            clear_curve();
        end else begin
            last_x    = p.pos_x;
            last_y    = p.pos_y;
            last_z    = p.pos_z;
            have_last = 1'b1;
        end
    endfunction

    task automatic check_result(bdsf_pkg::t_out_item got);
        bdsf_pkg::t_out_item exp_r;
        if (kept_points.size() == 0) begin
            report_mismatch($sformatf("unexpected result id %08h", got.out_id));
            return;
        end
        exp_r = kept_points.pop_front();
        if (got.out_x !== exp_r.out_x)
            report_mismatch($sformatf("out_x %0d, want %0d", got.out_x, exp_r.out_x));
        if (got.out_y !== exp_r.out_y)
            report_mismatch($sformatf("out_y %0d, want %0d", got.out_y, exp_r.out_y));
        if (got.out_z !== exp_r.out_z)
            report_mismatch($sformatf("out_z %0d, want %0d", got.out_z, exp_r.out_z));
        if (got.out_id !== exp_r.out_id)
            report_mismatch($sformatf("out_id %08h, want %08h", got.out_id, exp_r.out_id));
        if (got.run_last !== exp_r.run_last)
            report_mismatch($sformatf("run_last %b, want %b (id %08h)",
                                      got.run_last, exp_r.run_last, exp_r.out_id));
        if (got.curve_end !== exp_r.curve_end)
            report_mismatch($sformatf("curve_end %b, want %b (id %08h)",
                                      got.curve_end, exp_r.curve_end, exp_r.out_id));
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_point(i_in_item);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (point_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_item  <= point_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                check_result(o_out_item);
            end
            i_out_stall <= holdoff_on || ($urandom_range(99) < recv_idle_pct);
        end
    end

    // long output hold-off
    initial begin
        holdoff_on = 1'b0;
        wait (holdoff_arm);
        @(posedge i_clk);
        holdoff_on <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge i_clk);
        holdoff_on <= 1'b0;
    end

    task automatic write_reg(logic [1:0] reg_idx, logic [bdsf_pkg::DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bdsf_pkg::ADDR_W'({reg_idx, 3'b000});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(longint unsigned thr, int unsigned min_len, bit enable);
        write_reg(bdsf_pkg::REG_BREAK_DIST_SQ, bdsf_pkg::DATA_W'(thr));
        write_reg(bdsf_pkg::REG_MIN_SEGMENT_LEN, bdsf_pkg::DATA_W'(min_len));
        write_reg(bdsf_pkg::REG_RING_ENABLE, bdsf_pkg::DATA_W'(enable));
        cfg_break_dist_sq = bdsf_pkg::THR_W'(thr);
        cfg_min_len       = bdsf_pkg::LEN_W'(min_len);
        cfg_enable        = enable;
    endtask

    task automatic wait_idle();
        while (point_queue.size() > 0 || i_in_valid || kept_points.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_point(int x, int y, int z, logic [bdsf_pkg::ID_W-1:0] id, bit last);
        bdsf_pkg::t_in_item p;
        p.pos_x      = bdsf_pkg::COORD_BITS'(x);
        p.pos_y      = bdsf_pkg::COORD_BITS'(y);
        p.pos_z      = bdsf_pkg::COORD_BITS'(z);
        p.point_id   = id;
        p.curve_last = last;
        point_queue.insert(point_queue.size(), p);
    endtask

    function automatic bdsf_pkg::t_in_item random_point();
        bdsf_pkg::t_in_item p;
        p.pos_x      = bdsf_pkg::COORD_BITS'($urandom);
        p.pos_y      = bdsf_pkg::COORD_BITS'($urandom);
        p.pos_z      = bdsf_pkg::COORD_BITS'($urandom);
        p.point_id   = $urandom;
        p.curve_last = ($urandom_range(7) == 0);
        return p;
    endfunction

    // random walk along a ring with occasional jumps
    task automatic queue_curve(int unsigned len, int unsigned step, int unsigned jump_pct);
        bdsf_pkg::t_in_item p;
        p = random_point();
        for (int unsigned k = 0; k < len; k++) begin
            if (k > 0) begin
                if ($urandom_range(99) < jump_pct) begin
                    p.pos_x = bdsf_pkg::COORD_BITS'($urandom);
                    p.pos_y = bdsf_pkg::COORD_BITS'($urandom);
                    p.pos_z = bdsf_pkg::COORD_BITS'($urandom);
                end else begin
                    p.pos_x = p.pos_x + bdsf_pkg::COORD_BITS'($urandom_range(2 * step))
                            - bdsf_pkg::COORD_BITS'(step);
                    p.pos_y = p.pos_y + bdsf_pkg::COORD_BITS'($urandom_range(2 * step))
                            - bdsf_pkg::COORD_BITS'(step);
                    p.pos_z = p.pos_z + bdsf_pkg::COORD_BITS'($urandom_range(2 * step))
                            - bdsf_pkg::COORD_BITS'(step);
                end
            end
            p.point_id   = $urandom;
            p.curve_last = (k == len - 1);
            point_queue.insert(point_queue.size(), p);
        end
    endtask

    task automatic queue_random_curves(int unsigned n_items, int unsigned len_min,
                                       int unsigned len_max, int unsigned step,
                                       int unsigned jump_pct);
        int unsigned queued;
        int unsigned len;
        queued = 0;
        while (queued < n_items) begin
            if ($urandom_range(9) == 0) begin
                point_queue.insert(point_queue.size(), random_point());
                queued++;
            end else begin
                len = $urandom_range(len_max, len_min);
                queue_curve(len, step, jump_pct);
                queued += len;
            end
        end
    endtask

    initial begin
        int unsigned step;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_item     = '0;
        i_out_stall   = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        holdoff_arm   = 1'b0;
        err_count     = 0;
        send_idle_pct = 31;
        recv_idle_pct = 71;
        cfg_break_dist_sq = '0;
        cfg_min_len       = bdsf_pkg::LEN_W'(1);
        cfg_enable        = 1'b1;
        clear_curve();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // gap exactly at threshold (no break), short segment drop, short final segment
        set_config(300, 3, 1'b1);
        queue_point(0, 0, 0, 1, 1'b0);
        queue_point(10, 10, 10, 2, 1'b0);
        queue_point(20, 20, 21, 3, 1'b0);
        queue_point(20, 20, 22, 4, 1'b0);
        queue_point(20, 20, 23, 5, 1'b0);
        queue_point(20, 21, 23, 6, 1'b0);
        queue_point(-32768, -32768, -32768, 7, 1'b0);
        queue_point(32767, 32767, 32767, 8, 1'b0);
        queue_point(32767, 32767, 32767, 9, 1'b1);
        queue_point(5, 5, 5, 10, 1'b1);
        wait_idle();

        // largest threshold, zero minimum
        set_config(THR_MAX, 0, 1'b1);
        queue_point(-32768, 32767, -32768, 32'h0000_0000, 1'b0);
        queue_point(32767, -32768, 32767, 32'hFFFF_FFFF, 1'b0);
        queue_point(0, 0, 0, 32'h5555_AAAA, 1'b1);
        wait_idle();

        // zero threshold, minimum above buffer depth
        set_config(0, 40, 1'b1);
        queue_point(7, 7, 7, 14, 1'b0);
        queue_point(7, 7, 7, 15, 1'b0);
        queue_point(7, 7, 8, 16, 1'b1);
        wait_idle();

        // disabled ring clears the curve
        set_config(300, 2, 1'b1);
        queue_point(1, 1, 1, 17, 1'b0);
        wait_idle();
        set_config(300, 2, 1'b0);
        queue_point(2, 2, 2, 18, 1'b0);
        wait_idle();
        set_config(300, 2, 1'b1);
        queue_point(2, 1, 1, 19, 1'b0);
        queue_point(3, 1, 1, 20, 1'b1);
        wait_idle();

        step = $urandom_range(200, 4);
        set_config(3 * step * step, $urandom_range(6, 1), 1'b1);
        queue_random_curves(100, 1, 12, step, 10);
        wait_idle();

        send_idle_pct = 71;
        recv_idle_pct = 31;
        set_config(THR_MAX, 63, 1'b1);
        queue_random_curves(50, 5, 40, 300, 0);
        wait_idle();

        set_config(0, 0, 1'b1);
        queue_random_curves(30, 1, 8, 0, 20);
        wait_idle();

        set_config(THR_MAX, 1, 1'b0);
        for (int k = 0; k < 20; k++) begin
            point_queue.insert(point_queue.size(), random_point());
        end
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        step = $urandom_range(100, 2);
        set_config(3 * step * step, 1, 1'b1);
        holdoff_arm = 1'b1;
        queue_random_curves(70, 5, 30, step, 5);
        wait_idle();

        if (kept_points.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", kept_points.size()));
        end
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
